### rtl/flcb_pkg.sv
// package for the free-look camera basis unit
// word types, register indexes, sequencer states and fixed-point constants
// no dependencies
`default_nettype none

package flcb_pkg;

	// input word: one look or move command
	typedef struct packed {
		logic               command;
		logic signed [15:0] delta_x;
		logic signed [15:0] delta_y;
		logic [1:0]         move_direction;
		logic [15:0]        delta_time;
	} cam_in_t;

	// result word: position and basis
	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [15:0] front_x;
		logic signed [15:0] front_y;
		logic signed [15:0] front_z;
		logic signed [15:0] right_x;
		logic signed [15:0] right_z;
		logic signed [15:0] up_x;
		logic signed [15:0] up_y;
		logic signed [15:0] up_z;
	} cam_out_t;

	// command codes
	localparam logic CMD_LOOK = 1'b0;
	localparam logic CMD_MOVE = 1'b1;

	// move directions
	localparam logic [1:0] DIR_FORWARD  = 2'd0;
	localparam logic [1:0] DIR_BACKWARD = 2'd1;
	localparam logic [1:0] DIR_LEFT     = 2'd2;
	localparam logic [1:0] DIR_RIGHT    = 2'd3;

	// register indexes
	localparam logic [1:0] REG_LOOK_SCALE  = 2'd0;
	localparam logic [1:0] REG_MOVE_SPEED  = 2'd1;
	localparam logic [1:0] REG_PITCH_LIMIT = 2'd2;

	// register reset values
	localparam logic [15:0] LOOK_SCALE_RST  = 16'd27;
	localparam logic [15:0] MOVE_SPEED_RST  = 16'd3277;
	localparam logic [13:0] PITCH_LIMIT_RST = 14'd12780;

	// angles in Q3.13 radians
	localparam logic signed [15:0] PI_Q13      = 16'sd25736;
	localparam logic signed [15:0] HALF_PI_Q13 = 16'sd12868;
	localparam logic [33:0]        TWO_PI_Q13  = 34'd51472;
	localparam logic [15:0]        WRAP_DIV    = 16'd51472;
	// offset that keeps the yaw sum positive before the modulo
	localparam logic [33:0]        WRAP_BIAS   = 34'd3373268992;
	// yaw modulo: quotient estimate by reciprocal, then a few compare-subtracts
	// floor(2^31 / 2pi in Q3.13); estimate = ((sum >> 16) * recip) >> 15, low by at most 4
	localparam logic [15:0]        WRAP_RECIP   = 16'd41721;
	localparam int                 WRAP_IN_SHIFT = 16;
	localparam int                 WRAP_Q_SHIFT  = 15;
	localparam int                 WRAP_STEPS    = 7;

	// cordic in Q2.30
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
	localparam int                 CORDIC_FRAC = 30;
	localparam int                 ANGLE_SHIFT = 17;
	localparam int                 VEL_FRAC    = 24;
	localparam int                 ATAN_LEN    = 24;

	localparam logic [29:0] ATAN_TAB [ATAN_LEN] = '{
		30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159,
		30'd67021687,  30'd33543516,  30'd16775851,  30'd8388437,
		30'd4194283,   30'd2097149,   30'd1048576,   30'd524288,
		30'd262144,    30'd131072,    30'd65536,     30'd32768,
		30'd16384,     30'd8192,      30'd4096,      30'd2048,
		30'd1024,      30'd512,       30'd256,       30'd128
	};

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCALE,
		ST_WRAP,
		ST_ROT_PREP,
		ST_ROT,
		ST_ROT_END,
		ST_BASIS,
		ST_VEL,
		ST_STEP,
		ST_DONE
	} flcb_state_t;

endpackage

`default_nettype wire

### rtl/free_look_camera_basis.sv
// free-look camera basis unit, top level
// uses flcb_pkg for word types, states and constants
`default_nettype none

// One command word at a time. A look word adds look_scale times the mouse
// x delta to yaw (wrapped into [-pi, pi)), subtracts look_scale times the
// y delta from pitch (clamped to the pitch limit, at most pi/2), then
// rebuilds front, right and up with a cordic sine/cosine. A move word
// steps the saturating position along front or right by move_speed *
// delta_time. Every word returns one result word. All math runs through
// one shared multiplier and one cordic stage under a small sequencer: a
// look word runs the scale products, the yaw wrap, two cordic passes and
// the basis products; a move word runs the velocity product and the
// position steps. cmd_stall is high while a word is in work; the result
// register lets the next word enter while a result waits.
module free_look_camera_basis #(
	parameter int CORDIC_STEPS       = 16,
	parameter int VECTOR_FRAC_BITS   = 14,
	parameter int POSITION_FRAC_BITS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cmd_valid,
	output logic                   cmd_stall,
	input  wire flcb_pkg::cam_in_t cmd_word,
	output logic                   res_valid,
	input  wire logic              res_stall,
	output flcb_pkg::cam_out_t     res_word,
	input  wire logic              cfg_we,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [15:0]       cfg_data
);
	import flcb_pkg::*;

	localparam int VW  = VECTOR_FRAC_BITS + 2;
	localparam int MA  = 34;
	localparam int MB  = (VW > 17) ? VW : 17;
	localparam int PW  = MA + MB;
	localparam int CW  = $clog2(((CORDIC_STEPS > WRAP_STEPS) ? CORDIC_STEPS : WRAP_STEPS) + 1);
	localparam int SH_STEP = VECTOR_FRAC_BITS + VEL_FRAC - POSITION_FRAC_BITS;
	localparam int SH_ROT  = CORDIC_FRAC - VECTOR_FRAC_BITS;
	localparam logic signed [VW-1:0] ONE = VW'(1) << VECTOR_FRAC_BITS;

	// round half up by sh bits, then clamp to plus or minus one
	function automatic logic signed [VW-1:0] rnd_clamp(input logic signed [PW:0] v,
		input int sh);
		logic signed [PW:0] t;
		begin
			t = (v + ((PW+1)'(1) <<< (sh - 1))) >>> sh;
			if (t > (PW+1)'(ONE))
				rnd_clamp = ONE;
			else if (t < -((PW+1)'(ONE)))
				rnd_clamp = -ONE;
			else
				rnd_clamp = t[VW-1:0];
		end
	endfunction

	// registers
	flcb_state_t state_q, state_d;
	logic [CW-1:0] cnt_q;
	logic [15:0] look_scale_q, move_speed_q;
	logic [13:0] pitch_limit_q;
	cam_in_t cmd_q;
	logic signed [15:0] yaw_q, pitch_q;
	logic signed [31:0] pos_q [3];
	logic signed [VW-1:0] front_q [3];
	logic signed [VW-1:0] right_x_q, right_z_q;
	logic signed [VW-1:0] up_q [3];
	logic [33:0] wrap_q;
	logic sel_q, flip_q;
	logic signed [33:0] x_q, y_q, z_q;
	logic signed [VW-1:0] cy_q, sy_q, cp_q, sp_q;
	logic signed [PW-1:0] prod_q, acc_q;
	logic [31:0] vel_q;
	logic out_valid_q;
	cam_out_t out_q;

	logic signed [MA-1:0] mul_a;
	logic signed [MB-1:0] mul_b;
	logic signed [PW-1:0] mul_p;
	logic out_free;

	// combinational helpers
	logic [13:0] lim;
	logic signed [PW:0] pit_sum;
	logic [33:0] wrap_red;
	logic signed [15:0] rot_a, rot_a_adj;
	logic signed [33:0] atan_v;
	logic signed [33:0] x_fin, y_fin;
	logic signed [VW-1:0] step_vec;
	logic signed [PW:0] step_amt, pos_new;
	logic [1:0] pidx;

	assign out_free = !out_valid_q || !res_stall;
	assign cmd_stall = (state_q != ST_IDLE);
	assign res_valid = out_valid_q;
	assign res_word = out_q;

	// shared multiplier at full product width
	assign mul_p = mul_a * mul_b;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid)
					state_d = (cmd_word.command == CMD_MOVE) ? ST_VEL : ST_SCALE;
			end
			ST_SCALE: begin
				if (cnt_q == CW'(2))
					state_d = ST_WRAP;
			end
			ST_WRAP: begin
				if (cnt_q == CW'(WRAP_STEPS - 1))
					state_d = ST_ROT_PREP;
			end
			ST_ROT_PREP: state_d = ST_ROT;
			ST_ROT: begin
				if (cnt_q == CW'(CORDIC_STEPS - 1))
					state_d = ST_ROT_END;
			end
			ST_ROT_END: state_d = sel_q ? ST_BASIS : ST_ROT_PREP;
			ST_BASIS: begin
				if (cnt_q == CW'(6))
					state_d = ST_DONE;
			end
			ST_VEL: begin
				if (cnt_q == CW'(1))
					state_d = ST_STEP;
			end
			ST_STEP: begin
				if (cnt_q == CW'(3))
					state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// step vector for a move word
	always_comb begin
		pidx = cnt_q[1:0] - 2'd1;
		if (cnt_q[1:0] == 2'd3)
			step_vec = '0;
		else if (cmd_q.move_direction == DIR_FORWARD || cmd_q.move_direction == DIR_BACKWARD)
			step_vec = front_q[cnt_q[1:0]];
		else if (cnt_q[1:0] == 2'd0)
			step_vec = right_x_q;
		else if (cnt_q[1:0] == 2'd2)
			step_vec = right_z_q;
		else
			step_vec = '0;
	end

	// multiplier operand selection
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_SCALE: begin
				mul_a = (cnt_q == '0) ? MA'(cmd_q.delta_x) : MA'(cmd_q.delta_y);
				mul_b = MB'(signed'({1'b0, look_scale_q}));
			end
			ST_WRAP: begin
				// quotient estimate, then quotient times 2pi
				if (cnt_q == '0) begin
					mul_a = MA'(signed'({1'b0, wrap_q[33:WRAP_IN_SHIFT]}));
					mul_b = MB'(signed'({1'b0, WRAP_RECIP}));
				end else if (cnt_q == CW'(1)) begin
					mul_a = MA'(prod_q >>> WRAP_Q_SHIFT);
					mul_b = MB'(signed'({1'b0, WRAP_DIV}));
				end
			end
			ST_BASIS: begin
				case (cnt_q[2:0])
					3'd0: begin mul_a = MA'(cy_q); mul_b = MB'(cp_q); end
					3'd1: begin mul_a = MA'(sy_q); mul_b = MB'(cp_q); end
					3'd2: begin mul_a = MA'(cy_q); mul_b = MB'(front_q[0]); end
					3'd3: begin mul_a = MA'(sy_q); mul_b = MB'(front_q[2]); end
					3'd4: begin mul_a = MA'(cy_q); mul_b = MB'(sp_q); end
					3'd5: begin mul_a = MA'(sy_q); mul_b = MB'(sp_q); end
					default: begin mul_a = '0; mul_b = '0; end
				endcase
			end
			ST_VEL: begin
				mul_a = MA'(signed'({1'b0, move_speed_q}));
				mul_b = MB'(signed'({1'b0, cmd_q.delta_time}));
			end
			ST_STEP: begin
				mul_a = MA'(signed'({1'b0, vel_q}));
				mul_b = MB'(step_vec);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// shared datapath values
	always_comb begin
		lim = (pitch_limit_q > 14'(HALF_PI_Q13)) ? 14'(HALF_PI_Q13) : pitch_limit_q;
		pit_sum = (PW+1)'(pitch_q) - (PW+1)'(prod_q);
		wrap_red = (wrap_q >= TWO_PI_Q13) ? wrap_q - TWO_PI_Q13 : wrap_q;
		rot_a = sel_q ? pitch_q : yaw_q;
		if (rot_a > HALF_PI_Q13)
			rot_a_adj = rot_a - PI_Q13;
		else if (rot_a < -HALF_PI_Q13)
			rot_a_adj = rot_a + PI_Q13;
		else
			rot_a_adj = rot_a;
		atan_v = 34'(signed'({1'b0, ATAN_TAB[cnt_q]}));
		x_fin = flip_q ? -x_q : x_q;
		y_fin = flip_q ? -y_q : y_q;
		step_amt = ((PW+1)'(prod_q) + ((PW+1)'(1) <<< (SH_STEP - 1))) >>> SH_STEP;
		if ((cmd_q.move_direction == DIR_BACKWARD) || (cmd_q.move_direction == DIR_LEFT))
			pos_new = (PW+1)'(pos_q[pidx]) - step_amt;
		else
			pos_new = (PW+1)'(pos_q[pidx]) + step_amt;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
			look_scale_q <= LOOK_SCALE_RST;
			move_speed_q <= MOVE_SPEED_RST;
			pitch_limit_q <= PITCH_LIMIT_RST;
			yaw_q <= '0;
			pitch_q <= '0;
			pos_q[0] <= '0;
			pos_q[1] <= '0;
			pos_q[2] <= '0;
			front_q[0] <= ONE;
			front_q[1] <= '0;
			front_q[2] <= '0;
			right_x_q <= '0;
			right_z_q <= ONE;
			up_q[0] <= '0;
			up_q[1] <= ONE;
			up_q[2] <= '0;
			sel_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// configuration writes
			if (cfg_we) begin
				case (cfg_index)
					REG_LOOK_SCALE:  look_scale_q <= cfg_data;
					REG_MOVE_SPEED:  move_speed_q <= cfg_data;
					REG_PITCH_LIMIT: pitch_limit_q <= cfg_data[13:0];
					default: ;
				endcase
			end
			// result register
			if (state_q == ST_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !res_stall)
				out_valid_q <= 1'b0;
			// step counter
			if (state_d != state_q)
				cnt_q <= '0;
			else
				cnt_q <= cnt_q + CW'(1);
			// angle and basis state
			case (state_q)
				ST_SCALE: begin
					if (cnt_q == CW'(2)) begin
						if (pit_sum > (PW+1)'(signed'({1'b0, lim})))
							pitch_q <= 16'(lim);
						else if (pit_sum < -((PW+1)'(signed'({1'b0, lim}))))
							pitch_q <= -16'(lim);
						else
							pitch_q <= pit_sum[15:0];
					end
					sel_q <= 1'b0;
				end
				ST_WRAP: begin
					if (cnt_q == CW'(WRAP_STEPS - 1))
						yaw_q <= 16'(wrap_red - 34'(PI_Q13));
				end
				ST_ROT_END: sel_q <= 1'b1;
				ST_BASIS: begin
					case (cnt_q[2:0])
						3'd1: front_q[0] <= rnd_clamp((PW+1)'(prod_q), VECTOR_FRAC_BITS);
						3'd2: begin
							front_q[2] <= rnd_clamp((PW+1)'(prod_q), VECTOR_FRAC_BITS);
							front_q[1] <= sp_q;
							right_x_q <= -sy_q;
							right_z_q <= cy_q;
						end
						3'd4: up_q[1] <= rnd_clamp((PW+1)'(acc_q) + (PW+1)'(prod_q),
							VECTOR_FRAC_BITS);
						3'd5: up_q[0] <= rnd_clamp(-((PW+1)'(prod_q)), VECTOR_FRAC_BITS);
						3'd6: up_q[2] <= rnd_clamp(-((PW+1)'(prod_q)), VECTOR_FRAC_BITS);
						default: ;
					endcase
				end
				ST_STEP: begin
					if (cnt_q != '0) begin
						if (pos_new > (PW+1)'(32'sh7fffffff))
							pos_q[pidx] <= 32'sh7fffffff;
						else if (pos_new < (PW+1)'(-33'sh80000000))
							pos_q[pidx] <= 32'sh80000000;
						else
							pos_q[pidx] <= pos_new[31:0];
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		if (state_q == ST_IDLE && cmd_valid)
			cmd_q <= cmd_word;
		case (state_q)
			ST_SCALE: begin
				if (cnt_q == CW'(1))
					wrap_q <= 34'((PW+1)'(yaw_q) + (PW+1)'(prod_q) + (PW+1)'(PI_Q13)
						+ (PW+1)'(WRAP_BIAS));
			end
			ST_WRAP: begin
				// remove the estimated multiple of 2pi, then trim what is left
				if (cnt_q == CW'(2))
					wrap_q <= wrap_q - prod_q[33:0];
				else if (cnt_q > CW'(2))
					wrap_q <= wrap_red;
			end
			ST_ROT_PREP: begin
				flip_q <= (rot_a != rot_a_adj);
				z_q <= 34'(rot_a_adj) <<< ANGLE_SHIFT;
				x_q <= CORDIC_GAIN;
				y_q <= '0;
			end
			ST_ROT: begin
				if (!z_q[33]) begin
					x_q <= x_q - (y_q >>> cnt_q);
					y_q <= y_q + (x_q >>> cnt_q);
					z_q <= z_q - atan_v;
				end else begin
					x_q <= x_q + (y_q >>> cnt_q);
					y_q <= y_q - (x_q >>> cnt_q);
					z_q <= z_q + atan_v;
				end
			end
			ST_ROT_END: begin
				if (sel_q) begin
					cp_q <= rnd_clamp((PW+1)'(x_fin), SH_ROT);
					sp_q <= rnd_clamp((PW+1)'(y_fin), SH_ROT);
				end else begin
					cy_q <= rnd_clamp((PW+1)'(x_fin), SH_ROT);
					sy_q <= rnd_clamp((PW+1)'(y_fin), SH_ROT);
				end
			end
			ST_BASIS: begin
				if (cnt_q == CW'(3))
					acc_q <= prod_q;
			end
			ST_VEL: begin
				if (cnt_q == CW'(1))
					vel_q <= prod_q[31:0];
			end
			default: ;
		endcase
		// load the result word
		if (state_q == ST_DONE && out_free) begin
			out_q.pos_x <= pos_q[0];
			out_q.pos_y <= pos_q[1];
			out_q.pos_z <= pos_q[2];
			out_q.front_x <= 16'(front_q[0]);
			out_q.front_y <= 16'(front_q[1]);
			out_q.front_z <= 16'(front_q[2]);
			out_q.right_x <= 16'(right_x_q);
			out_q.right_z <= 16'(right_z_q);
			out_q.up_x <= 16'(up_q[0]);
			out_q.up_y <= 16'(up_q[1]);
			out_q.up_z <= 16'(up_q[2]);
		end
	end

endmodule

`default_nettype wire

### rtl/flcb_checker.sv
// port-level checks for the free-look camera basis unit
// uses flcb_pkg word types; bound to free_look_camera_basis
`default_nettype none

module flcb_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               cmd_valid,
	input wire logic               cmd_stall,
	input wire logic               res_valid,
	input wire logic               res_stall,
	input wire flcb_pkg::cam_out_t res_word
);
	import flcb_pkg::*;

	// a stalled result word holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_word))
		else $error("result word changed under stall");

	// an accepted word keeps the unit busy in the next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> cmd_stall)
		else $error("unit not busy after accepting a word");

	// no result can appear the cycle after a word is taken
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> !$rose(res_valid))
		else $error("result appeared too early");

	// the unit goes idle only when a result is produced
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(cmd_stall) |-> res_valid)
		else $error("unit went idle without a result");

endmodule

bind free_look_camera_basis flcb_checker u_flcb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd_valid),
	.cmd_stall (cmd_stall),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res_word  (res_word)
);

`default_nettype wire
